@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker chgs_checker. Each use expects clk and
// rst_n to be visible in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on the same edge as its antecedent
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition on the edge after its antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/chgs_pkg.sv @@
// ----------------------------------------------------------------------------
// chgs_pkg
// Shared types and constants of the Graham scan convex hull core.
// ----------------------------------------------------------------------------
package chgs_pkg;

    // Most hull vertices emitted for one set
    localparam int RESULT_CAP = 64;

    // Main sequencer states
    typedef enum logic [4:0] {
        S_LOAD,
        S_ANC_RD,
        S_ANC_CMP,
        S_SORT_RD,
        S_SORT_PT,
        S_SORT_DI,
        S_SORT_CHK,
        S_SORT_J,
        S_SORT_JPT,
        S_SORT_TURN,
        S_SORT_DJ,
        S_SORT_INS,
        S_SCAN_INIT,
        S_SCAN_RD,
        S_SCAN_C,
        S_SCAN_CPT,
        S_SCAN_CHK,
        S_SCAN_TURN,
        S_SCAN_SEC,
        S_SCAN_SECPT,
        S_SCAN_PUSH,
        S_EMIT_RD,
        S_EMIT_V,
        S_EMIT_LD,
        S_EMIT_OUT
    } state_t;

    // Multiply-accumulate unit phases
    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_P1,
        MAC_P2,
        MAC_P3
    } mac_phase_t;

endpackage

@@ sv/chgs_mac.sv @@
// ----------------------------------------------------------------------------
// chgs_mac
// Computes a*b + c*d in phases P1 to P3 with one shared multiplier. Serves
// both the cross product sign test and the squared distance.
// ----------------------------------------------------------------------------
module chgs_mac #(
    parameter int OP_W  = 18,
    parameter int RES_W = 37
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [OP_W-1:0]  a,
    input  logic signed [OP_W-1:0]  b,
    input  logic signed [OP_W-1:0]  c,
    input  logic signed [OP_W-1:0]  d,
    output logic                    done,
    output logic signed [RES_W-1:0] result
);

    chgs_pkg::mac_phase_t phase_reg, phase_next;
    logic                     done_reg;
    logic signed [OP_W-1:0]   a_reg, b_reg, c_reg, d_reg;
    logic signed [OP_W-1:0]   m1, m2;
    logic signed [2*OP_W-1:0] prod_reg;
    logic signed [RES_W-1:0]  acc_reg;

    // Advance through the three multiply phases
    always_comb
    begin
        unique case (phase_reg)
            chgs_pkg::MAC_IDLE: phase_next = start ? chgs_pkg::MAC_P1 : chgs_pkg::MAC_IDLE;
            chgs_pkg::MAC_P1:   phase_next = chgs_pkg::MAC_P2;
            chgs_pkg::MAC_P2:   phase_next = chgs_pkg::MAC_P3;
            chgs_pkg::MAC_P3:   phase_next = chgs_pkg::MAC_IDLE;
            default:            phase_next = chgs_pkg::MAC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= chgs_pkg::MAC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == chgs_pkg::MAC_P3);
        end
    end

    // Pick the operand pair for the current phase
    assign m1 = (phase_reg == chgs_pkg::MAC_P1) ? a_reg : c_reg;
    assign m2 = (phase_reg == chgs_pkg::MAC_P1) ? b_reg : d_reg;

    // Latch operands, multiply, then accumulate
    always_ff @(posedge clk)
    begin
        if (phase_reg == chgs_pkg::MAC_IDLE && start)
        begin
            a_reg <= a;
            b_reg <= b;
            c_reg <= c;
            d_reg <= d;
        end
        prod_reg <= m1 * m2;
        if (phase_reg == chgs_pkg::MAC_P2)
            acc_reg <= RES_W'(prod_reg);
        else if (phase_reg == chgs_pkg::MAC_P3)
            acc_reg <= acc_reg + RES_W'(prod_reg);
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

@@ sv/convex_hull_graham_scan_core.sv @@
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_core
// Collects points into a store, then finds the anchor, insertion-sorts the
// rest by angle and runs the stack scan, emitting the hull in CCW order.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid in_ready point_x point_y     | sink
//           | last_point                            |
//   out     | out_valid out_ready hull_x hull_y     | source
//           | last_vertex overflowed                |
//
// A point that is not last is taken whenever in_valid is high. After the
// last point the core searches the stored points for the anchor, sorts the
// rest by insertion on cross product sign and, on equal angles, distance
// (quadratic in the point count at worst), runs the scan with a turn test
// per candidate and pops, and holds each vertex until it is taken. The
// shared multiplier and the single store read port serialise these steps.
// Reset needs no clearing pass. in_ready is low from the last point until
// the last vertex is taken.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan_core #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] hull_x,
    output logic signed [COORD_BITS-1:0] hull_y,
    output logic                         last_vertex,
    output logic                         overflowed
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PT_W  = 2 * COORD_BITS;
    localparam int OP_W  = COORD_BITS + 2;
    localparam int RES_W = 2 * OP_W + 1;

    chgs_pkg::state_t state_reg, state_next;

    // Memories
    logic [PT_W-1:0]  store_mem [MAX_POINTS];
    logic [IDX_W-1:0] sort_mem  [MAX_POINTS];
    logic [IDX_W-1:0] stack_mem [MAX_POINTS];
    logic [PT_W-1:0]  st_rd_reg;
    logic [IDX_W-1:0] sort_rd_reg, stack_rd_reg;

    logic             st_we, sort_we, stack_we;
    logic [IDX_W-1:0] st_waddr, st_raddr, sort_waddr, sort_raddr;
    logic [IDX_W-1:0] stack_waddr, stack_raddr;
    logic [IDX_W-1:0] sort_wdata, stack_wdata;

    // Control and working registers
    logic [CNT_W-1:0] count_reg, i_reg, m_reg, pos_reg, k_reg, depth_reg, e_reg, n_reg;
    logic             ovf_reg;
    logic [IDX_W-1:0] anc_reg, j_reg, c_reg, top_reg, sec_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, xi_reg, yi_reg, xj_reg, yj_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, tx_reg, ty_reg, sx_reg, sy_reg;
    logic signed [RES_W-1:0]      di_reg;
    logic signed [COORD_BITS-1:0] hx_reg, hy_reg;
    logic                         hlast_reg, hovf_reg;

    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic                         accept, store_full, prec, is_anchor_copy;
    logic [CNT_W-1:0]             pos_m1, depth_m1, depth_m3;

    // Multiplier unit
    logic                    mac_start, mac_done;
    logic signed [OP_W-1:0]  mac_a, mac_b, mac_c, mac_d;
    logic signed [RES_W-1:0] mac_res;

    chgs_mac #(
        .OP_W  (OP_W),
        .RES_W (RES_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .a      (mac_a),
        .b      (mac_b),
        .c      (mac_c),
        .d      (mac_d),
        .done   (mac_done),
        .result (mac_res)
    );

    assign rd_x       = st_rd_reg[PT_W-1:COORD_BITS];
    assign rd_y       = st_rd_reg[COORD_BITS-1:0];
    assign accept     = in_valid && in_ready;
    assign store_full = (count_reg >= CNT_W'(MAX_POINTS));
    assign pos_m1     = pos_reg - CNT_W'(1);
    assign depth_m1   = depth_reg - CNT_W'(1);
    assign depth_m3   = depth_reg - CNT_W'(3);
    assign is_anchor_copy = (rd_x == ax_reg) && (rd_y == ay_reg);

    // Angle order decision: sign of the cross product, then distance
    always_comb
    begin
        if (state_reg == chgs_pkg::S_SORT_TURN)
            prec = (mac_res > 0);
        else
            prec = (di_reg < mac_res);
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= {point_x, point_y};
        st_rd_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sort_we)
            sort_mem[sort_waddr] <= sort_wdata;
        sort_rd_reg <= sort_mem[sort_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chgs_pkg::S_LOAD:
                if (accept && last_point)
                    state_next = chgs_pkg::S_ANC_RD;
            chgs_pkg::S_ANC_RD:
                state_next = chgs_pkg::S_ANC_CMP;
            chgs_pkg::S_ANC_CMP:
                state_next = (i_reg + CNT_W'(1) == count_reg) ? chgs_pkg::S_SORT_RD
                                                              : chgs_pkg::S_ANC_RD;
            chgs_pkg::S_SORT_RD:
                state_next = (i_reg == count_reg) ? chgs_pkg::S_SCAN_INIT
                                                  : chgs_pkg::S_SORT_PT;
            chgs_pkg::S_SORT_PT:
                state_next = is_anchor_copy ? chgs_pkg::S_SORT_RD : chgs_pkg::S_SORT_DI;
            chgs_pkg::S_SORT_DI:
                if (mac_done)
                    state_next = chgs_pkg::S_SORT_CHK;
            chgs_pkg::S_SORT_CHK:
                state_next = (pos_reg == '0) ? chgs_pkg::S_SORT_INS : chgs_pkg::S_SORT_J;
            chgs_pkg::S_SORT_J:
                state_next = chgs_pkg::S_SORT_JPT;
            chgs_pkg::S_SORT_JPT:
                state_next = chgs_pkg::S_SORT_TURN;
            chgs_pkg::S_SORT_TURN:
                if (mac_done)
                begin
                    if (mac_res == '0)
                        state_next = chgs_pkg::S_SORT_DJ;
                    else
                        state_next = prec ? chgs_pkg::S_SORT_CHK : chgs_pkg::S_SORT_INS;
                end
            chgs_pkg::S_SORT_DJ:
                if (mac_done)
                    state_next = prec ? chgs_pkg::S_SORT_CHK : chgs_pkg::S_SORT_INS;
            chgs_pkg::S_SORT_INS:
                state_next = chgs_pkg::S_SORT_RD;
            chgs_pkg::S_SCAN_INIT:
                state_next = chgs_pkg::S_SCAN_RD;
            chgs_pkg::S_SCAN_RD:
                state_next = (k_reg == m_reg) ? chgs_pkg::S_EMIT_RD : chgs_pkg::S_SCAN_C;
            chgs_pkg::S_SCAN_C:
                state_next = chgs_pkg::S_SCAN_CPT;
            chgs_pkg::S_SCAN_CPT:
                state_next = chgs_pkg::S_SCAN_CHK;
            chgs_pkg::S_SCAN_CHK:
                state_next = (depth_reg >= CNT_W'(2)) ? chgs_pkg::S_SCAN_TURN
                                                      : chgs_pkg::S_SCAN_PUSH;
            chgs_pkg::S_SCAN_TURN:
                if (mac_done)
                begin
                    if (mac_res > 0)
                        state_next = chgs_pkg::S_SCAN_PUSH;
                    else if (depth_m1 >= CNT_W'(2))
                        state_next = chgs_pkg::S_SCAN_SEC;
                    else
                        state_next = chgs_pkg::S_SCAN_CHK;
                end
            chgs_pkg::S_SCAN_SEC:
                state_next = chgs_pkg::S_SCAN_SECPT;
            chgs_pkg::S_SCAN_SECPT:
                state_next = chgs_pkg::S_SCAN_CHK;
            chgs_pkg::S_SCAN_PUSH:
                state_next = chgs_pkg::S_SCAN_RD;
            chgs_pkg::S_EMIT_RD:
                state_next = chgs_pkg::S_EMIT_V;
            chgs_pkg::S_EMIT_V:
                state_next = chgs_pkg::S_EMIT_LD;
            chgs_pkg::S_EMIT_LD:
                state_next = chgs_pkg::S_EMIT_OUT;
            chgs_pkg::S_EMIT_OUT:
                if (out_ready)
                    state_next = hlast_reg ? chgs_pkg::S_LOAD : chgs_pkg::S_EMIT_RD;
            default:
                state_next = chgs_pkg::S_LOAD;
        endcase
    end

    // Memory addresses, write strobes and multiplier operands
    always_comb
    begin
        in_ready    = (state_reg == chgs_pkg::S_LOAD);
        out_valid   = (state_reg == chgs_pkg::S_EMIT_OUT);
        st_we       = 1'b0;
        st_waddr    = count_reg[IDX_W-1:0];
        st_raddr    = i_reg[IDX_W-1:0];
        sort_we     = 1'b0;
        sort_waddr  = pos_reg[IDX_W-1:0];
        sort_wdata  = j_reg;
        sort_raddr  = pos_m1[IDX_W-1:0];
        stack_we    = 1'b0;
        stack_waddr = depth_reg[IDX_W-1:0];
        stack_wdata = c_reg;
        stack_raddr = e_reg[IDX_W-1:0];
        mac_start   = 1'b0;
        mac_a       = OP_W'(xi_reg) - OP_W'(ax_reg);
        mac_b       = OP_W'(rd_y) - OP_W'(ay_reg);
        mac_c       = OP_W'(ay_reg) - OP_W'(yi_reg);
        mac_d       = OP_W'(rd_x) - OP_W'(ax_reg);
        unique case (state_reg)
            chgs_pkg::S_LOAD:
                st_we = accept && !store_full;
            chgs_pkg::S_SORT_PT:
            begin
                mac_start = !is_anchor_copy;
                mac_a     = OP_W'(rd_x) - OP_W'(ax_reg);
                mac_b     = OP_W'(rd_x) - OP_W'(ax_reg);
                mac_c     = OP_W'(rd_y) - OP_W'(ay_reg);
                mac_d     = OP_W'(rd_y) - OP_W'(ay_reg);
            end
            chgs_pkg::S_SORT_J:
                st_raddr = sort_rd_reg;
            chgs_pkg::S_SORT_JPT:
                mac_start = 1'b1;
            chgs_pkg::S_SORT_TURN:
            begin
                mac_start = mac_done && (mac_res == '0);
                mac_a     = OP_W'(xj_reg) - OP_W'(ax_reg);
                mac_b     = OP_W'(xj_reg) - OP_W'(ax_reg);
                mac_c     = OP_W'(yj_reg) - OP_W'(ay_reg);
                mac_d     = OP_W'(yj_reg) - OP_W'(ay_reg);
                sort_we   = mac_done && (mac_res != '0) && prec;
            end
            chgs_pkg::S_SORT_DJ:
                sort_we = mac_done && prec;
            chgs_pkg::S_SORT_INS:
            begin
                sort_we    = 1'b1;
                sort_wdata = i_reg[IDX_W-1:0];
            end
            chgs_pkg::S_SCAN_INIT:
            begin
                stack_we    = 1'b1;
                stack_waddr = '0;
                stack_wdata = anc_reg;
            end
            chgs_pkg::S_SCAN_RD:
                sort_raddr = k_reg[IDX_W-1:0];
            chgs_pkg::S_SCAN_C:
                st_raddr = sort_rd_reg;
            chgs_pkg::S_SCAN_CHK:
            begin
                mac_start = (depth_reg >= CNT_W'(2));
                mac_a     = OP_W'(tx_reg) - OP_W'(sx_reg);
                mac_b     = OP_W'(cy_reg) - OP_W'(sy_reg);
                mac_c     = OP_W'(sy_reg) - OP_W'(ty_reg);
                mac_d     = OP_W'(cx_reg) - OP_W'(sx_reg);
            end
            chgs_pkg::S_SCAN_TURN:
                stack_raddr = depth_m3[IDX_W-1:0];
            chgs_pkg::S_SCAN_SEC:
                st_raddr = stack_rd_reg;
            chgs_pkg::S_SCAN_PUSH:
                stack_we = (depth_reg < CNT_W'(MAX_POINTS));
            chgs_pkg::S_EMIT_V:
                st_raddr = stack_rd_reg;
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chgs_pkg::S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == chgs_pkg::S_LOAD && accept)
            begin
                if (store_full)
                    ovf_reg <= 1'b1;
                else
                    count_reg <= count_reg + CNT_W'(1);
            end
            if (state_reg == chgs_pkg::S_EMIT_OUT && out_ready && hlast_reg)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // Working registers of the anchor search, sort, scan and output
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            chgs_pkg::S_LOAD:
                i_reg <= '0;
            chgs_pkg::S_ANC_CMP:
            begin
                if (i_reg == '0 || rd_y < ay_reg || (rd_y == ay_reg && rd_x > ax_reg))
                begin
                    anc_reg <= i_reg[IDX_W-1:0];
                    ax_reg  <= rd_x;
                    ay_reg  <= rd_y;
                end
                if (i_reg + CNT_W'(1) == count_reg)
                begin
                    i_reg <= '0;
                    m_reg <= '0;
                end
                else
                    i_reg <= i_reg + CNT_W'(1);
            end
            chgs_pkg::S_SORT_PT:
            begin
                xi_reg  <= rd_x;
                yi_reg  <= rd_y;
                pos_reg <= m_reg;
                if (is_anchor_copy)
                    i_reg <= i_reg + CNT_W'(1);
            end
            chgs_pkg::S_SORT_DI:
                di_reg <= mac_res;
            chgs_pkg::S_SORT_J:
                j_reg <= sort_rd_reg;
            chgs_pkg::S_SORT_JPT:
            begin
                xj_reg <= rd_x;
                yj_reg <= rd_y;
            end
            chgs_pkg::S_SORT_TURN:
                if (mac_done && mac_res != '0 && prec)
                    pos_reg <= pos_m1;
            chgs_pkg::S_SORT_DJ:
                if (mac_done && prec)
                    pos_reg <= pos_m1;
            chgs_pkg::S_SORT_INS:
            begin
                m_reg <= m_reg + CNT_W'(1);
                i_reg <= i_reg + CNT_W'(1);
            end
            chgs_pkg::S_SCAN_INIT:
            begin
                depth_reg <= CNT_W'(1);
                top_reg   <= anc_reg;
                tx_reg    <= ax_reg;
                ty_reg    <= ay_reg;
                k_reg     <= '0;
            end
            chgs_pkg::S_SCAN_RD:
            begin
                e_reg <= '0;
                if (32'(depth_reg) > chgs_pkg::RESULT_CAP)
                    n_reg <= CNT_W'(chgs_pkg::RESULT_CAP);
                else
                    n_reg <= depth_reg;
            end
            chgs_pkg::S_SCAN_C:
                c_reg <= sort_rd_reg;
            chgs_pkg::S_SCAN_CPT:
            begin
                cx_reg <= rd_x;
                cy_reg <= rd_y;
            end
            chgs_pkg::S_SCAN_TURN:
                // pop: the second entry becomes the top
                if (mac_done && !(mac_res > 0))
                begin
                    depth_reg <= depth_m1;
                    top_reg   <= sec_reg;
                    tx_reg    <= sx_reg;
                    ty_reg    <= sy_reg;
                end
            chgs_pkg::S_SCAN_SEC:
                sec_reg <= stack_rd_reg;
            chgs_pkg::S_SCAN_SECPT:
            begin
                sx_reg <= rd_x;
                sy_reg <= rd_y;
            end
            chgs_pkg::S_SCAN_PUSH:
            begin
                if (depth_reg < CNT_W'(MAX_POINTS))
                begin
                    depth_reg <= depth_reg + CNT_W'(1);
                    sec_reg   <= top_reg;
                    sx_reg    <= tx_reg;
                    sy_reg    <= ty_reg;
                    top_reg   <= c_reg;
                    tx_reg    <= cx_reg;
                    ty_reg    <= cy_reg;
                end
                k_reg <= k_reg + CNT_W'(1);
            end
            chgs_pkg::S_EMIT_LD:
            begin
                hx_reg    <= rd_x;
                hy_reg    <= rd_y;
                hlast_reg <= (e_reg + CNT_W'(1) == n_reg);
                hovf_reg  <= ovf_reg;
            end
            chgs_pkg::S_EMIT_OUT:
                if (out_ready)
                    e_reg <= e_reg + CNT_W'(1);
            default:
            begin
            end
        endcase
    end

    assign hull_x      = hx_reg;
    assign hull_y      = hy_reg;
    assign last_vertex = hlast_reg;
    assign overflowed  = hovf_reg;

endmodule

@@ sv/chgs_checker.sv @@
// ----------------------------------------------------------------------------
// chgs_checker
// Port-level checks of the convex hull core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chgs_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic signed [COORD_BITS-1:0] point_x,
    input logic signed [COORD_BITS-1:0] point_y,
    input logic                         last_point,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [COORD_BITS-1:0] hull_x,
    input logic signed [COORD_BITS-1:0] hull_y,
    input logic                         last_vertex,
    input logic                         overflowed
);

    // A stalled item holds its payload
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hull_x) && $stable(hull_y) && $stable(last_vertex) && $stable(overflowed), "stalled hull item changed")

    // Loading and emitting never overlap
    `ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input open while emitting")

    // After the final vertex the core takes points again
    `ASSERT_NEXT(a_reopen, out_valid && out_ready && last_vertex, in_ready && !out_valid, "core did not reopen after final vertex")

    // A taken vertex that is not final is followed by a fetch gap
    `ASSERT_NEXT(a_fetch_gap, out_valid && out_ready && !last_vertex, !out_valid && !in_ready, "next vertex shown too early")

endmodule

bind convex_hull_graham_scan_core chgs_checker #(.COORD_BITS(COORD_BITS)) u_chgs_checker (.*);
